/* rtl/rounded_rect_tessellator_macros.svh */
// Assertion helpers shared by the checker.
`ifndef ROUNDED_RECT_TESSELLATOR_MACROS_SVH
`define ROUNDED_RECT_TESSELLATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RRT_ASSERT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rounded_rect_tessellator port check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RRT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rounded_rect_tessellator port check failed");

`endif

/* rtl/rrt_pkg.sv */
package rrt_pkg;

   localparam int ArcSteps     = 8;
   localparam int PtsPerCorner = ArcSteps + 1;
   localparam int PerimPoints  = 4 * PtsPerCorner;
   localparam int SegW         = 6;
   localparam int KW           = $clog2(PtsPerCorner);
   localparam int RadW         = 18;
   localparam int SinW         = 16;
   localparam int CoordW       = 23;
   localparam int VtxW         = 24;
   localparam int OutW         = 21;
   localparam int DeltaW       = 20;
   localparam int L2W          = 2 * DeltaW + 1;
   localparam int L2LoW        = 21;
   localparam int ThickW       = 12;
   localparam int MagW         = ThickW;
   localparam int OddW         = MagW + 1;
   localparam int QW           = 2 * OddW;
   localparam int NtW          = DeltaW + ThickW;
   localparam int RhsW         = 2 * NtW;
   localparam int BitIdxW      = $clog2(MagW);
   localparam int FifoDepth    = 4;
   localparam int FifoPtrW     = $clog2(FifoDepth);

   // Quarter-wave sine in Q15, one entry per arc point (ArcSteps + 1 entries).
   localparam logic [SinW-1:0] SinTable [0:ArcSteps] = '{
      16'd0, 16'd6393, 16'd12540, 16'd18205, 16'd23170,
      16'd27246, 16'd30274, 16'd32138, 16'd32768
   };

   localparam logic signed [VtxW-1:0] CoordMax = VtxW'((1 << (OutW - 1)) - 1);
   localparam logic signed [VtxW-1:0] CoordMin = -CoordMax - VtxW'(1);

   typedef enum logic [2:0] {
      CSR_LEFT, CSR_TOP, CSR_WIDTH, CSR_HEIGHT,
      CSR_RADIUS, CSR_FILL_RGBA, CSR_STROKE_RGBA, CSR_STROKE_WIDTH
   } csr_reg_type;

   typedef enum logic [1:0] {
      CORNER_TL, CORNER_TR, CORNER_BR, CORNER_BL
   } corner_type;

   typedef enum logic [2:0] {
      OFF_IDLE, OFF_PREP, OFF_RHS, OFF_SQ, OFF_MUL, OFF_CMP
   } off_state_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_SEARCH, BK_EMIT
   } back_state_type;

   typedef enum logic [3:0] {
      VX_CENTER, VX_FILL_S, VX_FILL_E, VX_A0, VX_B, VX_C0, VX_A1, VX_C1, VX_D
   } vtx_sel_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [14:0]        width;
      logic [14:0]        height;
      logic [13:0]        radius;
      logic [31:0]        fill_rgba;
      logic [31:0]        stroke_rgba;
      logic [ThickW-1:0]  stroke_width;
   } cfg_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
   } pt_type;

   typedef struct packed {
      logic signed [CoordW-1:0] sx;
      logic signed [CoordW-1:0] sy;
      logic signed [CoordW-1:0] ex;
      logic signed [CoordW-1:0] ey;
      logic                     neg_ox;
      logic                     neg_oy;
      logic [DeltaW-1:0]        adx;
      logic [DeltaW-1:0]        ady;
      logic                     fill_en;
      logic                     stroke_en;
   } seg_item_type;

   // Corner of a perimeter point, found by comparing against the corner starts.
   function automatic corner_type point_corner(input logic [SegW-1:0] idx);
      if (idx >= SegW'(3 * PtsPerCorner)) return CORNER_BL;
      if (idx >= SegW'(2 * PtsPerCorner)) return CORNER_BR;
      if (idx >= SegW'(PtsPerCorner)) return CORNER_TR;
      return CORNER_TL;
   endfunction

   // Position inside the corner arc: the index minus the corner's first point.
   function automatic logic [KW-1:0] point_step(input logic [SegW-1:0] idx);
      logic [SegW-1:0] base;
      case (point_corner(idx))
         CORNER_TL: base = '0;
         CORNER_TR: base = SegW'(PtsPerCorner);
         CORNER_BR: base = SegW'(2 * PtsPerCorner);
         default:   base = SegW'(3 * PtsPerCorner);
      endcase
      return KW'(idx - base);
   endfunction

   // (r * s + 0.5) in Q15, result never exceeds r.
   function automatic logic [RadW-1:0] radius_term(input logic [RadW-1:0] r,
                                                   input logic [SinW-1:0] s);
      logic [RadW+SinW:0] p;
      p = (RadW+SinW+1)'(r) * (RadW+SinW+1)'(s) + (RadW+SinW+1)'(16384);
      return p[RadW+14:15];
   endfunction

   function automatic pt_type corner_point(input corner_type c,
                                           input logic [RadW-1:0] a,
                                           input logic [RadW-1:0] b,
                                           input logic signed [CoordW-1:0] xl,
                                           input logic signed [CoordW-1:0] xr,
                                           input logic signed [CoordW-1:0] yt,
                                           input logic signed [CoordW-1:0] yb);
      logic signed [CoordW-1:0] as;
      logic signed [CoordW-1:0] bs;
      pt_type p;
      as = $signed(CoordW'(a));
      bs = $signed(CoordW'(b));
      case (c)
         CORNER_TL: begin p.x = xl - as; p.y = yt - bs; end
         CORNER_TR: begin p.x = xr + bs; p.y = yt - as; end
         CORNER_BR: begin p.x = xr + as; p.y = yb + bs; end
         default:   begin p.x = xl - bs; p.y = yb + as; end
      endcase
      return p;
   endfunction

   function automatic logic [OutW-1:0] sat_coord(input logic signed [VtxW-1:0] v);
      if (v > CoordMax) return CoordMax[OutW-1:0];
      if (v < CoordMin) return CoordMin[OutW-1:0];
      return v[OutW-1:0];
   endfunction

endpackage

/* rtl/rrt_fifo.sv */
module rrt_fifo import rrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  seg_item_type din,
   input  logic         pop,
   output seg_item_type dout,
   output logic         full,
   output logic         empty
);

   seg_item_type          mem_ff [FifoDepth];
   logic [FifoPtrW-1:0]   wr_ff, wr_in;
   logic [FifoPtrW-1:0]   rd_ff, rd_in;
   logic [FifoPtrW:0]     cnt_ff, cnt_in;

   assign full  = (cnt_ff == (FifoPtrW+1)'(FifoDepth));
   assign empty = (cnt_ff == '0);
   assign dout  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (FifoPtrW+1)'(push) - (FifoPtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

/* rtl/rrt_front.sv */
module rrt_front import rrt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic [RadW-1:0] reff,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [SegW-1:0] req_seg,
   output logic            push,
   output seg_item_type    item,
   input  logic            full
);

   logic adv;
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // Stage 0: accepted segment.
   logic [SegW-1:0] seg0_ff;

   // Stage 1: point lookup.
   logic            ok1_ff, ok1_in;
   corner_type      cs1_ff, cs1_in, ce1_ff, ce1_in;
   logic [SinW-1:0] sas1_ff, sas1_in, sbs1_ff, sbs1_in;
   logic [SinW-1:0] sae1_ff, sae1_in, sbe1_ff, sbe1_in;
   logic [SegW-1:0] idx_e;
   logic [KW-1:0]   ks, ke;

   // Stage 2: radius terms.
   logic            ok2_ff;
   corner_type      cs2_ff, ce2_ff;
   logic [RadW-1:0] as2_ff, bs2_ff, ae2_ff, be2_ff;

   // Stage 3: end points.
   logic                     ok3_ff;
   pt_type                   ps3_ff, ps3_in, pe3_ff, pe3_in;
   logic signed [CoordW-1:0] x0, y0, xl, xr, yt, yb, rs;

   // Stage 4: deltas and squares.
   logic                     ok4_ff;
   pt_type                   ps4_ff, pe4_ff;
   logic signed [CoordW-1:0] dx, dy;
   logic [DeltaW-1:0]        adx4_ff, adx4_in, ady4_ff, ady4_in;
   logic                     nox4_ff, noy4_ff;
   logic [2*DeltaW-1:0]      sqx4_ff, sqx4_in, sqy4_ff, sqy4_in;

   // Stage 5: finished item.
   seg_item_type     item5_ff, item5_in;
   logic [L2W-1:0]   l2;

   assign adv       = !(v5_ff && full);
   assign req_ready = adv;
   assign push      = v5_ff && !full && (item5_ff.fill_en || item5_ff.stroke_en);
   assign item      = item5_ff;

   always_comb begin
      ok1_in  = (seg0_ff < SegW'(PerimPoints));
      idx_e   = (seg0_ff == SegW'(PerimPoints - 1)) ? '0 : seg0_ff + 1'b1;
      cs1_in  = point_corner(seg0_ff);
      ce1_in  = point_corner(idx_e);
      ks      = point_step(seg0_ff);
      ke      = point_step(idx_e);
      if (!ok1_in) begin
         ks = '0;
         ke = '0;
      end
      sas1_in = SinTable[KW'(ArcSteps) - ks];
      sbs1_in = SinTable[ks];
      sae1_in = SinTable[KW'(ArcSteps) - ke];
      sbe1_in = SinTable[ke];
   end

   always_comb begin
      x0 = CoordW'(cfg.left) <<< 4;
      y0 = CoordW'(cfg.top) <<< 4;
      rs = $signed(CoordW'(reff));
      xl = x0 + rs;
      yt = y0 + rs;
      xr = x0 + $signed(CoordW'({cfg.width, 4'b0})) - rs;
      yb = y0 + $signed(CoordW'({cfg.height, 4'b0})) - rs;
      ps3_in = corner_point(cs2_ff, as2_ff, bs2_ff, xl, xr, yt, yb);
      pe3_in = corner_point(ce2_ff, ae2_ff, be2_ff, xl, xr, yt, yb);
   end

   always_comb begin
      dx      = pe3_ff.x - ps3_ff.x;
      dy      = pe3_ff.y - ps3_ff.y;
      adx4_in = DeltaW'(dx < 0 ? -dx : dx);
      ady4_in = DeltaW'(dy < 0 ? -dy : dy);
      sqx4_in = (2*DeltaW)'(adx4_in) * (2*DeltaW)'(adx4_in);
      sqy4_in = (2*DeltaW)'(ady4_in) * (2*DeltaW)'(ady4_in);
   end

   always_comb begin
      l2                 = L2W'(sqx4_ff) + L2W'(sqy4_ff);
      item5_in.sx        = ps4_ff.x;
      item5_in.sy        = ps4_ff.y;
      item5_in.ex        = pe4_ff.x;
      item5_in.ey        = pe4_ff.y;
      item5_in.neg_ox    = nox4_ff;
      item5_in.neg_oy    = noy4_ff;
      item5_in.adx       = adx4_ff;
      item5_in.ady       = ady4_ff;
      item5_in.fill_en   = ok4_ff && (cfg.fill_rgba[7:0] != '0);
      item5_in.stroke_en = ok4_ff && (cfg.stroke_width != '0)
                           && (cfg.stroke_rgba[7:0] != '0) && (l2 != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg0_ff  <= req_seg;
         ok1_ff   <= ok1_in && v0_ff;
         cs1_ff   <= cs1_in;
         ce1_ff   <= ce1_in;
         sas1_ff  <= sas1_in;
         sbs1_ff  <= sbs1_in;
         sae1_ff  <= sae1_in;
         sbe1_ff  <= sbe1_in;
         ok2_ff   <= ok1_ff;
         cs2_ff   <= cs1_ff;
         ce2_ff   <= ce1_ff;
         as2_ff   <= radius_term(reff, sas1_ff);
         bs2_ff   <= radius_term(reff, sbs1_ff);
         ae2_ff   <= radius_term(reff, sae1_ff);
         be2_ff   <= radius_term(reff, sbe1_ff);
         ok3_ff   <= ok2_ff;
         ps3_ff   <= ps3_in;
         pe3_ff   <= pe3_in;
         ok4_ff   <= ok3_ff;
         ps4_ff   <= ps3_ff;
         pe4_ff   <= pe3_ff;
         adx4_ff  <= adx4_in;
         ady4_ff  <= ady4_in;
         nox4_ff  <= (dy > 0);
         noy4_ff  <= (dx < 0);
         sqx4_ff  <= sqx4_in;
         sqy4_ff  <= sqy4_in;
         item5_ff <= item5_in;
      end
   end

endmodule

/* rtl/rrt_offset.sv */
module rrt_offset import rrt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DeltaW-1:0] num,
   input  logic [L2W-1:0]    l2,
   input  logic [ThickW-1:0] thick,
   output logic              busy,
   output logic [MagW-1:0]   mag
);

   // Finds the largest m with (2m-1)^2 * l2 <= (num*thick)^2, m <= ceil(thick/2),
   // one result bit per square, multiply, compare round.
   off_state_type          state_ff, state_in;
   logic [DeltaW-1:0]      num_ff;
   logic [L2W-1:0]         l2_ff;
   logic [ThickW-1:0]      thick_ff;
   logic [MagW-1:0]        hi_ff, m_ff, trial;
   logic [BitIdxW-1:0]     bit_ff;
   logic [NtW-1:0]         nt_ff;
   logic [RhsW-1:0]        rhs_ff;
   logic [QW-1:0]          q_ff;
   logic [QW+L2LoW-1:0]    plo_ff;
   logic [QW+L2W-L2LoW-1:0] phi_ff;
   logic [OddW-1:0]        odd;
   logic [QW+L2W-1:0]      total;
   logic [ThickW:0]        tp1;
   logic                   take;

   assign busy = (state_ff != OFF_IDLE);
   assign mag  = m_ff;

   always_comb begin
      trial = m_ff | (MagW'(1) << bit_ff);
      odd   = {trial, 1'b0} - OddW'(1);
      total = (QW+L2W)'(plo_ff) + ((QW+L2W)'(phi_ff) << L2LoW);
      take  = (trial <= hi_ff) && (total <= (QW+L2W)'(rhs_ff));
      tp1   = {1'b0, thick} + (ThickW+1)'(1);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         OFF_IDLE: if (start) state_in = OFF_PREP;
         OFF_PREP: state_in = OFF_RHS;
         OFF_RHS:  state_in = OFF_SQ;
         OFF_SQ:   state_in = OFF_MUL;
         OFF_MUL:  state_in = OFF_CMP;
         OFF_CMP:  state_in = (bit_ff == '0) ? OFF_IDLE : OFF_SQ;
         default:  state_in = OFF_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OFF_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         OFF_IDLE: begin
            if (start) begin
               num_ff   <= num;
               l2_ff    <= l2;
               thick_ff <= thick;
               hi_ff    <= tp1[ThickW:1];
            end
         end
         OFF_PREP: nt_ff <= NtW'(num_ff) * NtW'(thick_ff);
         OFF_RHS: begin
            rhs_ff <= RhsW'(nt_ff) * RhsW'(nt_ff);
            m_ff   <= '0;
            bit_ff <= BitIdxW'(MagW - 1);
         end
         OFF_SQ:  q_ff <= QW'(odd) * QW'(odd);
         OFF_MUL: begin
            plo_ff <= (QW+L2LoW)'(q_ff) * (QW+L2LoW)'(l2_ff[L2LoW-1:0]);
            phi_ff <= (QW+L2W-L2LoW)'(q_ff) * (QW+L2W-L2LoW)'(l2_ff[L2W-1:L2LoW]);
         end
         OFF_CMP: begin
            if (take) m_ff <= trial;
            if (bit_ff != '0) bit_ff <= bit_ff - 1'b1;
         end
         default: ;
      endcase
   end

endmodule

/* rtl/rrt_back.sv */
module rrt_back import rrt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           empty,
   input  seg_item_type   item,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [OutW-1:0] rsp_x,
   output logic [OutW-1:0] rsp_y,
   output logic [31:0]    rsp_rgba,
   output logic           rsp_stroke,
   output logic           rsp_last
);

   back_state_type state_ff, state_in;
   vtx_sel_type    idx_ff, idx_in, last_idx;
   seg_item_type   cur_ff, cur_in;
   logic           start, busy_x, busy_y, out_load, load_vtx;
   logic [MagW-1:0] mag_x, mag_y;

   logic                   valid_ff, valid_in;
   logic [OutW-1:0]        x_ff, y_ff;
   logic [31:0]            rgba_ff;
   logic                   stroke_ff, last_ff;

   logic signed [VtxW-1:0] sx, sy, ex, ey, ox, oy, cx, cy, vx, vy;

   rrt_offset u_off_x (
      .clock (clock), .reset (reset), .start (start), .num (item.ady),
      .l2 (L2W'(item.adx) * L2W'(item.adx) + L2W'(item.ady) * L2W'(item.ady)),
      .thick (cfg.stroke_width), .busy (busy_x), .mag (mag_x)
   );

   rrt_offset u_off_y (
      .clock (clock), .reset (reset), .start (start), .num (item.adx),
      .l2 (L2W'(item.adx) * L2W'(item.adx) + L2W'(item.ady) * L2W'(item.ady)),
      .thick (cfg.stroke_width), .busy (busy_y), .mag (mag_y)
   );

   assign out_load   = !valid_ff || rsp_ready;
   assign last_idx   = cur_ff.stroke_en ? VX_D : VX_FILL_E;
   assign rsp_valid  = valid_ff;
   assign rsp_x      = x_ff;
   assign rsp_y      = y_ff;
   assign rsp_rgba   = rgba_ff;
   assign rsp_stroke = stroke_ff;
   assign rsp_last   = last_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cur_in   = cur_ff;
      pop      = 1'b0;
      start    = 1'b0;
      load_vtx = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               cur_in = item;
               idx_in = VX_CENTER;
               if (item.stroke_en) begin
                  start    = 1'b1;
                  state_in = BK_SEARCH;
               end else begin
                  state_in = BK_EMIT;
               end
            end
         end
         BK_SEARCH: begin
            if (!busy_x && !busy_y) begin
               state_in = BK_EMIT;
               idx_in   = cur_ff.fill_en ? VX_CENTER : VX_A0;
            end
         end
         BK_EMIT: begin
            if (out_load) begin
               load_vtx = 1'b1;
               if (idx_ff == last_idx) begin
                  state_in = BK_IDLE;
               end else begin
                  idx_in = vtx_sel_type'(idx_ff + 1'b1);
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      sx = VtxW'(cur_ff.sx);
      sy = VtxW'(cur_ff.sy);
      ex = VtxW'(cur_ff.ex);
      ey = VtxW'(cur_ff.ey);
      ox = cur_ff.neg_ox ? -$signed(VtxW'(mag_x)) : $signed(VtxW'(mag_x));
      oy = cur_ff.neg_oy ? -$signed(VtxW'(mag_y)) : $signed(VtxW'(mag_y));
      cx = (VtxW'(cfg.left) <<< 4) + $signed(VtxW'({cfg.width, 3'b0}));
      cy = (VtxW'(cfg.top) <<< 4) + $signed(VtxW'({cfg.height, 3'b0}));
      case (idx_ff)
         VX_CENTER: begin vx = cx;      vy = cy;      end
         VX_FILL_S: begin vx = sx;      vy = sy;      end
         VX_FILL_E: begin vx = ex;      vy = ey;      end
         VX_A0:     begin vx = sx + ox; vy = sy + oy; end
         VX_B:      begin vx = sx - ox; vy = sy - oy; end
         VX_C0:     begin vx = ex - ox; vy = ey - oy; end
         VX_A1:     begin vx = sx + ox; vy = sy + oy; end
         VX_C1:     begin vx = ex - ox; vy = ey - oy; end
         VX_D:      begin vx = ex + ox; vy = ey + oy; end
         default:   begin vx = cx;      vy = cy;      end
      endcase
      valid_in = load_vtx ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= VX_CENTER;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (load_vtx) begin
         x_ff      <= sat_coord(vx);
         y_ff      <= sat_coord(vy);
         stroke_ff <= (idx_ff >= VX_A0);
         rgba_ff   <= (idx_ff >= VX_A0) ? cfg.stroke_rgba : cfg.fill_rgba;
         last_ff   <= (idx_ff == last_idx);
      end
   end

endmodule

/* rtl/rounded_rect_tessellator.sv */
// Rounded rectangle tessellator.
// Configure the rectangle, corner radius, fill and stroke through the csr_
// write channel (index 0..7 selects left, top, width, height, radius, fill
// color, stroke color, stroke width) while the block is idle. Then send
// segment numbers on the req_ channel, one beat each; each segment returns
// up to nine vertex beats on the rsp_ channel: a fill triangle (center, start,
// end) when fill alpha is nonzero, then two stroke triangles when stroke
// width and alpha are nonzero and the segment has nonzero length. tlast marks
// the final vertex of a segment; segments that yield nothing return no beat.
// A six-stage front pipeline computes the end points and feeds a four-entry
// queue. Fill-only segments leave the back end at one vertex per cycle
// while rsp_tready is high, after a fetch from the queue. Stroked segments
// first run the offset search (a product and square setup, then a square,
// multiply and compare round per result bit, twelve bits), then emit their
// vertices. Synchronous reset empties the pipeline and queue and clears the
// configuration registers to zero. A stalled rsp_ side holds its beat; the
// queue then fills and req_tready drops, so no beat is lost.
module rounded_rect_tessellator import rrt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] segment_number
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [20:0] vertex_x, [41:21] vertex_y, [73:42] vertex_rgba
   output logic        rsp_tlast,   // last_vertex
   output logic        rsp_tuser,   // from_stroke
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type         cfg_ff;
   logic [RadW-1:0] reff_ff, reff_in;
   logic [RadW:0]   r2;
   logic            push, pop, full, empty;
   seg_item_type    fifo_in, fifo_out;
   logic [OutW-1:0] vx, vy;
   logic [31:0]     rgba;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            CSR_LEFT:         cfg_ff.left         <= csr_data[15:0];
            CSR_TOP:          cfg_ff.top          <= csr_data[15:0];
            CSR_WIDTH:        cfg_ff.width        <= csr_data[14:0];
            CSR_HEIGHT:       cfg_ff.height       <= csr_data[14:0];
            CSR_RADIUS:       cfg_ff.radius       <= csr_data[13:0];
            CSR_FILL_RGBA:    cfg_ff.fill_rgba    <= csr_data;
            CSR_STROKE_RGBA:  cfg_ff.stroke_rgba  <= csr_data;
            CSR_STROKE_WIDTH: cfg_ff.stroke_width <= csr_data[ThickW-1:0];
            default: ;
         endcase
      end
   end

   // Effective radius in 1/16 pixel: clamp to half the width, then half the height.
   always_comb begin
      reff_in = {cfg_ff.radius, 4'b0};
      if ({cfg_ff.radius, 1'b0} > {1'b0, cfg_ff.width}) begin
         reff_in = {cfg_ff.width, 3'b0};
      end
      r2 = {reff_in, 1'b0};
      if (r2 > (RadW+1)'({cfg_ff.height, 4'b0})) begin
         reff_in = {cfg_ff.height, 3'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reff_ff <= '0;
      end else begin
         reff_ff <= reff_in;
      end
   end

   rrt_front u_front (
      .clock (clock), .reset (reset), .cfg (cfg_ff), .reff (reff_ff),
      .req_valid (req_tvalid), .req_ready (req_tready), .req_seg (req_tdata[SegW-1:0]),
      .push (push), .item (fifo_in), .full (full)
   );

   rrt_fifo u_fifo (
      .clock (clock), .reset (reset), .push (push), .din (fifo_in),
      .pop (pop), .dout (fifo_out), .full (full), .empty (empty)
   );

   rrt_back u_back (
      .clock (clock), .reset (reset), .cfg (cfg_ff), .empty (empty), .item (fifo_out),
      .pop (pop), .rsp_valid (rsp_tvalid), .rsp_ready (rsp_tready),
      .rsp_x (vx), .rsp_y (vy), .rsp_rgba (rgba),
      .rsp_stroke (rsp_tuser), .rsp_last (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, rgba, vy, vx};

endmodule

/* rtl/rrt_checker.sv */
`include "rounded_rect_tessellator_macros.svh"

module rrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // A waiting vertex beat keeps its data and last flag.
   `RRT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Nothing is offered right out of reset.
   `RRT_ASSERT(a_rsp_after_reset, $fell(reset), !rsp_tvalid)

   // The request side always shows a defined ready while a beat is offered.
   `RRT_ASSERT(a_req_ready_known, req_tvalid, !$isunknown(req_tready))

   // Vertices of one segment leave without gaps once the receiver takes them.
   `RRT_ASSERT_NEXT(a_seg_run, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)

   // Stroke vertices of a segment are never followed by fill vertices of it.
   `RRT_ASSERT_NEXT(a_stroke_run, rsp_tvalid && rsp_tready && rsp_tuser && !rsp_tlast, rsp_tvalid && rsp_tuser)

endmodule

bind rounded_rect_tessellator rrt_checker u_rrt_checker (.*);
